// ===== rtl/kgcp_pkg.sv =====
package kgcp_pkg;

    // ascii codes of the recognized bases, both cases
    localparam logic [7:0] CHAR_A    = 8'h41;
    localparam logic [7:0] CHAR_C    = 8'h43;
    localparam logic [7:0] CHAR_G    = 8'h47;
    localparam logic [7:0] CHAR_T    = 8'h54;
    localparam logic [7:0] CHAR_A_LO = 8'h61;
    localparam logic [7:0] CHAR_C_LO = 8'h63;
    localparam logic [7:0] CHAR_G_LO = 8'h67;
    localparam logic [7:0] CHAR_T_LO = 8'h74;

    // two-bit base codes, first base most significant in a bin index
    localparam logic [1:0] CODE_A = 2'd0;
    localparam logic [1:0] CODE_C = 2'd1;
    localparam logic [1:0] CODE_G = 2'd2;
    localparam logic [1:0] CODE_T = 2'd3;

    // transaction kinds
    localparam logic MODE_BASE = 1'b0;
    localparam logic MODE_READ = 1'b1;

    // field widths
    localparam int CNT_W     = 32;
    localparam int SLOT_IN_W = 6;
    localparam int NMER_W    = 3;

    // result queue sizing
    localparam int OUT_DEPTH = 3;
    localparam int OUT_PTR_W = 2;
    localparam int OUT_CNT_W = 2;

    localparam logic [CNT_W-1:0] SAT_MAX = '1;

    typedef enum logic [1:0] {
        PH_CLEAR = 2'b01,
        PH_RUN   = 2'b10
    } phase_t;

    typedef struct packed {
        logic       ok;
        logic [1:0] code;
    } base_code_t;

    // one memory operation handed from the issue stage to the update stage
    typedef struct packed {
        logic tot;   // update slot totals
        logic bin;   // touch a bin counter
        logic rd;    // read-out, no write
        logic two;   // bin gets plus two (palindromic window)
        logic win;   // window total gets plus two
        logic gc;    // gc count gets plus one
        logic ok;    // slot in range
    } op_t;

    typedef struct packed {
        logic [CNT_W-1:0] window_sum;
        logic [CNT_W-1:0] gc_sum;
        logic [CNT_W-1:0] base_sum;
    } totals_t;

    typedef struct packed {
        logic [CNT_W-1:0] bin_count;
        totals_t          totals;
    } result_t;

    // classify an ascii base; anything else is not ok and enters as code A
    function automatic base_code_t base_code(input logic [7:0] ch);
        base_code_t r;
        r.ok   = 1'b1;
        r.code = CODE_A;
        case (ch)
            CHAR_A, CHAR_A_LO: r.code = CODE_A;
            CHAR_C, CHAR_C_LO: r.code = CODE_C;
            CHAR_G, CHAR_G_LO: r.code = CODE_G;
            CHAR_T, CHAR_T_LO: r.code = CODE_T;
            default:           r.ok   = 1'b0;
        endcase
        return r;
    endfunction

    // saturating add of a small increment
    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] v,
                                                  input logic [1:0] d);
        logic [CNT_W:0] s;
        s = {1'b0, v} + {{(CNT_W - 1){1'b0}}, d};
        return s[CNT_W] ? SAT_MAX : s[CNT_W-1:0];
    endfunction

endpackage

// ===== rtl/kmer_gc_profile_per_barcode_top.sv =====
// read-out path: issue stage (held for queue credit), update stage, result queue
// throughput: one transaction per cycle unless a read-out waits for queue credit;
//   a base whose window hits two distinct bins takes a second step, set by the
//   single read-modify-write port of the bin memory; reset clears control at once,
//   then a clearing pass zeroes bin memory and slot totals, with in_ready low
module kmer_gc_profile_per_barcode_top #(
    parameter int MAX_NMER = 4,
    parameter int SLOTS    = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            mode,
    input  logic [kgcp_pkg::SLOT_IN_W-1:0]  barcode_slot,
    input  logic [7:0]                      base_char,
    input  logic                            last_base,
    input  logic [7:0]                      bin_index,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [kgcp_pkg::CNT_W-1:0]      bin_count,
    output logic [kgcp_pkg::CNT_W-1:0]      window_sum,
    output logic [kgcp_pkg::CNT_W-1:0]      gc_sum,
    output logic [kgcp_pkg::CNT_W-1:0]      base_sum,
    input  logic                            cfg_wr_en,
    input  logic [kgcp_pkg::NMER_W-1:0]     cfg_wr_data
);

    localparam int BIN_AW    = 2 * MAX_NMER;
    localparam int BINS      = 1 << BIN_AW;
    localparam int MEM_DEPTH = SLOTS * BINS;
    localparam int SLOT_AW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int ADDR_W    = SLOT_AW + BIN_AW;
    localparam int RUN_W     = $clog2(MAX_NMER + 1);

    // memories
    logic [kgcp_pkg::CNT_W-1:0] bin_mem [0:MEM_DEPTH-1];
    kgcp_pkg::totals_t          tot_mem [0:SLOTS-1];

    // configuration and read window state
    logic [kgcp_pkg::NMER_W-1:0] nmer_len_reg;
    logic [BIN_AW-1:0]           recent_codes_reg, recent_codes_next;
    logic [RUN_W-1:0]            bases_in_read_reg, bases_in_read_next;
    logic [RUN_W-1:0]            clean_run_reg, clean_run_next;

    // clearing pass
    kgcp_pkg::phase_t  phase_reg;
    logic [ADDR_W-1:0] clr_addr_reg;

    // issue stage
    logic               a_valid_reg, a_valid_next;
    logic               a_step_reg, a_step_next;
    logic               a_read_reg, a_ok_reg, a_bins_reg, a_pair_reg, a_win_reg, a_gc_reg;
    logic [SLOT_AW-1:0] a_slot_reg;
    logic [BIN_AW-1:0]  a_fwd_reg, a_rc_reg;

    // update stage
    logic               m_valid_reg;
    kgcp_pkg::op_t      m_op_reg;
    logic [ADDR_W-1:0]  m_bin_addr_reg;
    logic [SLOT_AW-1:0] m_slot_reg;
    logic [kgcp_pkg::CNT_W-1:0] bin_rd_reg;
    kgcp_pkg::totals_t          tot_rd_reg;

    // forwarding of the latest writes
    logic                       bfw_valid_reg, tfw_valid_reg;
    logic [ADDR_W-1:0]          bfw_addr_reg;
    logic [SLOT_AW-1:0]         tfw_addr_reg;
    logic [kgcp_pkg::CNT_W-1:0] bfw_data_reg;
    kgcp_pkg::totals_t          tfw_data_reg;

    // result queue
    kgcp_pkg::result_t              fifo_mem_reg [0:kgcp_pkg::OUT_DEPTH-1];
    logic [kgcp_pkg::OUT_PTR_W-1:0] fifo_wr_ptr_reg, fifo_rd_ptr_reg;
    logic [kgcp_pkg::OUT_CNT_W-1:0] fifo_cnt_reg;

    // input decode
    logic                         in_accept;
    kgcp_pkg::base_code_t         bc;
    logic                         in_gc;
    logic                         slot_ok;
    logic [SLOT_AW+kgcp_pkg::SLOT_IN_W-1:0] slot_wide;
    logic [SLOT_AW-1:0]           slot_idx;
    logic [BIN_AW+7:0]            bin_wide;
    logic [RUN_W-1:0]             n_eff;
    logic [RUN_W-1:0]             rc_shift;
    logic [BIN_AW+1:0]            codes_cat;
    logic [BIN_AW-1:0]            codes_new;
    logic [BIN_AW-1:0]            win_mask;
    logic [BIN_AW-1:0]            fwd_idx, rc_full, rc_idx;
    logic [RUN_W-1:0]             bases_inc, clean_inc;
    logic                         win_full, win_clean;

    // issue control
    logic               credit_ok;
    logic               issue;
    logic               a_last_step;
    logic               a_leave;
    kgcp_pkg::op_t      iss_op;
    logic [ADDR_W-1:0]  iss_bin_addr;

    // update datapath
    logic                       bin_we, tot_we;
    logic [kgcp_pkg::CNT_W-1:0] bin_cur, bin_new;
    kgcp_pkg::totals_t          tot_cur, tot_new;
    logic [1:0]                 bin_inc;
    logic                       push, pop;
    kgcp_pkg::result_t          push_data;

    // effective window length
    always_comb
    begin
        if (nmer_len_reg == '0)
        begin
            n_eff = RUN_W'(1);
        end
        else if (32'(nmer_len_reg) > MAX_NMER)
        begin
            n_eff = RUN_W'(MAX_NMER);
        end
        else
        begin
            n_eff = RUN_W'(nmer_len_reg);
        end
    end

    // base classification and slot range
    always_comb
    begin
        bc        = kgcp_pkg::base_code(base_char);
        in_gc     = bc.ok && ((bc.code == kgcp_pkg::CODE_C) || (bc.code == kgcp_pkg::CODE_G));
        slot_ok   = 32'(barcode_slot) < SLOTS;
        slot_wide = {{SLOT_AW{1'b0}}, barcode_slot};
        slot_idx  = slot_wide[SLOT_AW-1:0];
        bin_wide  = {{BIN_AW{1'b0}}, bin_index};
    end

    // window update for an incoming base
    always_comb
    begin
        codes_cat = {recent_codes_reg, bc.code};
        codes_new = codes_cat[BIN_AW-1:0];
        bases_inc = (bases_in_read_reg < RUN_W'(MAX_NMER)) ?
                    bases_in_read_reg + RUN_W'(1) : bases_in_read_reg;
        if (bc.ok)
        begin
            clean_inc = (clean_run_reg < RUN_W'(MAX_NMER)) ?
                        clean_run_reg + RUN_W'(1) : clean_run_reg;
        end
        else
        begin
            clean_inc = '0;
        end
        win_full  = bases_inc >= n_eff;
        win_clean = clean_inc >= n_eff;
    end

    // forward and reverse-complement bin indexes
    always_comb
    begin
        for (int i = 0; i < MAX_NMER; i++)
        begin
            win_mask[2*i +: 2] = (RUN_W'(i) < n_eff) ? 2'b11 : 2'b00;
        end
        fwd_idx = codes_new & win_mask;
        for (int j = 0; j < MAX_NMER; j++)
        begin
            rc_full[2*j +: 2] = ~fwd_idx[2*(MAX_NMER-1-j) +: 2];
        end
        rc_shift = RUN_W'(MAX_NMER) - n_eff;
        rc_idx   = rc_full >> {rc_shift, 1'b0};
    end

    // issue control and input handshake
    always_comb
    begin
        credit_ok = ({1'b0, fifo_cnt_reg} + {{kgcp_pkg::OUT_CNT_W{1'b0}},
                     (m_valid_reg && m_op_reg.rd)}) <
                    (kgcp_pkg::OUT_CNT_W + 1)'(kgcp_pkg::OUT_DEPTH);
        issue       = a_valid_reg && (!a_read_reg || credit_ok);
        a_last_step = !(a_bins_reg && a_pair_reg && !a_read_reg && !a_step_reg);
        a_leave     = issue && a_last_step;
        in_ready    = (phase_reg == kgcp_pkg::PH_RUN) && (!a_valid_reg || a_leave);
        in_accept   = in_valid && in_ready;
    end

    // operation for the memory pipeline
    always_comb
    begin
        if (a_step_reg)
        begin
            iss_op.tot   = 1'b0;
            iss_op.bin   = 1'b1;
            iss_op.rd    = 1'b0;
            iss_op.two   = 1'b0;
            iss_op.win   = 1'b0;
            iss_op.gc    = 1'b0;
            iss_op.ok    = 1'b1;
            iss_bin_addr = {a_slot_reg, a_rc_reg};
        end
        else
        begin
            iss_op.tot   = !a_read_reg;
            iss_op.bin   = a_read_reg || a_bins_reg;
            iss_op.rd    = a_read_reg;
            iss_op.two   = a_bins_reg && !a_pair_reg;
            iss_op.win   = a_win_reg;
            iss_op.gc    = a_gc_reg;
            iss_op.ok    = a_ok_reg;
            iss_bin_addr = {a_slot_reg, a_fwd_reg};
        end
    end

    // issue stage next state
    always_comb
    begin
        a_valid_next = a_valid_reg;
        a_step_next  = a_step_reg;
        if (in_accept)
        begin
            a_valid_next = (mode == kgcp_pkg::MODE_READ) || slot_ok;
            a_step_next  = 1'b0;
        end
        else if (a_leave)
        begin
            a_valid_next = 1'b0;
        end
        else if (issue)
        begin
            a_step_next = 1'b1;
        end
    end

    // window state next values
    always_comb
    begin
        recent_codes_next  = recent_codes_reg;
        bases_in_read_next = bases_in_read_reg;
        clean_run_next     = clean_run_reg;
        if (in_accept && (mode == kgcp_pkg::MODE_BASE))
        begin
            if (last_base)
            begin
                recent_codes_next  = '0;
                bases_in_read_next = '0;
                clean_run_next     = '0;
            end
            else
            begin
                recent_codes_next  = codes_new;
                bases_in_read_next = bases_inc;
                clean_run_next     = clean_inc;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nmer_len_reg      <= kgcp_pkg::NMER_W'(2);
            recent_codes_reg  <= '0;
            bases_in_read_reg <= '0;
            clean_run_reg     <= '0;
            phase_reg         <= kgcp_pkg::PH_CLEAR;
            clr_addr_reg      <= '0;
            a_valid_reg       <= 1'b0;
            a_step_reg        <= 1'b0;
            m_valid_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                nmer_len_reg <= cfg_wr_data;
            end
            recent_codes_reg  <= recent_codes_next;
            bases_in_read_reg <= bases_in_read_next;
            clean_run_reg     <= clean_run_next;
            case (phase_reg)
                kgcp_pkg::PH_CLEAR:
                begin
                    if (clr_addr_reg == ADDR_W'(MEM_DEPTH - 1))
                    begin
                        phase_reg <= kgcp_pkg::PH_RUN;
                    end
                    else
                    begin
                        clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
                    end
                end
                kgcp_pkg::PH_RUN:
                begin
                    phase_reg <= kgcp_pkg::PH_RUN;
                end
                default:
                begin
                    phase_reg <= kgcp_pkg::PH_CLEAR;
                end
            endcase
            a_valid_reg <= a_valid_next;
            a_step_reg  <= a_step_next;
            m_valid_reg <= issue;
        end
    end

    // issue stage and update stage payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            a_read_reg <= mode == kgcp_pkg::MODE_READ;
            a_ok_reg   <= slot_ok;
            a_slot_reg <= slot_idx;
            if (mode == kgcp_pkg::MODE_READ)
            begin
                a_fwd_reg  <= bin_wide[BIN_AW-1:0];
                a_rc_reg   <= bin_wide[BIN_AW-1:0];
                a_bins_reg <= 1'b0;
                a_pair_reg <= 1'b0;
                a_win_reg  <= 1'b0;
                a_gc_reg   <= 1'b0;
            end
            else
            begin
                a_fwd_reg  <= fwd_idx;
                a_rc_reg   <= rc_idx;
                a_bins_reg <= win_full && win_clean;
                a_pair_reg <= fwd_idx != rc_idx;
                a_win_reg  <= win_full;
                a_gc_reg   <= in_gc;
            end
        end
        if (issue)
        begin
            m_op_reg       <= iss_op;
            m_bin_addr_reg <= iss_bin_addr;
            m_slot_reg     <= a_slot_reg;
        end
    end

    // update stage: merge forwarded data and add
    always_comb
    begin
        bin_cur = (bfw_valid_reg && (bfw_addr_reg == m_bin_addr_reg)) ? bfw_data_reg : bin_rd_reg;
        tot_cur = (tfw_valid_reg && (tfw_addr_reg == m_slot_reg)) ? tfw_data_reg : tot_rd_reg;
        bin_inc = m_op_reg.two ? 2'd2 : 2'd1;
        bin_new = kgcp_pkg::sat_add(bin_cur, bin_inc);
        tot_new.window_sum = kgcp_pkg::sat_add(tot_cur.window_sum,
                                               m_op_reg.win ? 2'd2 : 2'd0);
        tot_new.gc_sum     = kgcp_pkg::sat_add(tot_cur.gc_sum, {1'b0, m_op_reg.gc});
        tot_new.base_sum   = kgcp_pkg::sat_add(tot_cur.base_sum, 2'd1);
        bin_we = m_valid_reg && m_op_reg.bin && !m_op_reg.rd;
        tot_we = m_valid_reg && m_op_reg.tot;
        push   = m_valid_reg && m_op_reg.rd;
        if (m_op_reg.ok)
        begin
            push_data.bin_count = bin_cur;
            push_data.totals    = tot_cur;
        end
        else
        begin
            push_data = '0;
        end
    end

    // bin memory: clearing pass, write-back, registered read
    always_ff @(posedge clk)
    begin
        if (phase_reg == kgcp_pkg::PH_CLEAR)
        begin
            bin_mem[clr_addr_reg] <= '0;
        end
        else if (bin_we)
        begin
            bin_mem[m_bin_addr_reg] <= bin_new;
        end
        if (issue && iss_op.bin)
        begin
            bin_rd_reg <= bin_mem[iss_bin_addr];
        end
    end

    // slot totals memory
    always_ff @(posedge clk)
    begin
        if (phase_reg == kgcp_pkg::PH_CLEAR)
        begin
            tot_mem[clr_addr_reg[ADDR_W-1:BIN_AW]] <= '0;
        end
        else if (tot_we)
        begin
            tot_mem[m_slot_reg] <= tot_new;
        end
        if (issue && (iss_op.tot || iss_op.rd))
        begin
            tot_rd_reg <= tot_mem[a_slot_reg];
        end
    end

    // forwarding registers hold the most recent write of each memory
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bfw_valid_reg <= 1'b0;
            tfw_valid_reg <= 1'b0;
        end
        else
        begin
            if (bin_we)
            begin
                bfw_valid_reg <= 1'b1;
            end
            if (tot_we)
            begin
                tfw_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (bin_we)
        begin
            bfw_addr_reg <= m_bin_addr_reg;
            bfw_data_reg <= bin_new;
        end
        if (tot_we)
        begin
            tfw_addr_reg <= m_slot_reg;
            tfw_data_reg <= tot_new;
        end
    end

    // result queue
    assign pop       = out_valid && out_ready;
    assign out_valid = fifo_cnt_reg != '0;
    assign bin_count  = fifo_mem_reg[fifo_rd_ptr_reg].bin_count;
    assign window_sum = fifo_mem_reg[fifo_rd_ptr_reg].totals.window_sum;
    assign gc_sum     = fifo_mem_reg[fifo_rd_ptr_reg].totals.gc_sum;
    assign base_sum   = fifo_mem_reg[fifo_rd_ptr_reg].totals.base_sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fifo_wr_ptr_reg <= '0;
            fifo_rd_ptr_reg <= '0;
            fifo_cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                fifo_wr_ptr_reg <= (fifo_wr_ptr_reg ==
                                    kgcp_pkg::OUT_PTR_W'(kgcp_pkg::OUT_DEPTH - 1)) ?
                                   '0 : fifo_wr_ptr_reg + kgcp_pkg::OUT_PTR_W'(1);
            end
            if (pop)
            begin
                fifo_rd_ptr_reg <= (fifo_rd_ptr_reg ==
                                    kgcp_pkg::OUT_PTR_W'(kgcp_pkg::OUT_DEPTH - 1)) ?
                                   '0 : fifo_rd_ptr_reg + kgcp_pkg::OUT_PTR_W'(1);
            end
            if (push && !pop)
            begin
                fifo_cnt_reg <= fifo_cnt_reg + kgcp_pkg::OUT_CNT_W'(1);
            end
            else if (pop && !push)
            begin
                fifo_cnt_reg <= fifo_cnt_reg - kgcp_pkg::OUT_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem_reg[fifo_wr_ptr_reg] <= push_data;
        end
    end

`ifndef ASSERT_OFF
    // the read-out credit keeps the result queue from overflowing
    assert property (@(posedge clk) disable iff (!rst_n)
        !(push && !pop && (fifo_cnt_reg == kgcp_pkg::OUT_CNT_W'(kgcp_pkg::OUT_DEPTH))))
        else $error("result queue overflow");

    // no operation in flight while memories are being cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == kgcp_pkg::PH_CLEAR) |-> (!a_valid_reg && !m_valid_reg))
        else $error("operation during clearing pass");

    // a second bin step only follows a window with two distinct bins
    assert property (@(posedge clk) disable iff (!rst_n)
        (a_valid_reg && a_step_reg) |-> (a_bins_reg && a_pair_reg && !a_read_reg))
        else $error("unexpected second bin step");

    // a read-out enters the update stage only with a slot free in the queue
    assert property (@(posedge clk) disable iff (!rst_n)
        (issue && a_read_reg) |=> (fifo_cnt_reg != kgcp_pkg::OUT_CNT_W'(kgcp_pkg::OUT_DEPTH)))
        else $error("read-out issued without queue space");
`endif

endmodule

// ===== test/kmer_gc_profile_per_barcode_top_tb.sv =====
module kmer_gc_profile_per_barcode_top_tb;

    localparam int MAX_LEN     = 4;
    localparam int NUM_SLOTS   = 64;
    localparam int BIN_BITS    = 2 * MAX_LEN;
    localparam int LIMIT       = 400000;
    localparam int SETTLE      = 8;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 38;
    localparam int NUM_PHASES  = 9;
    localparam logic [7:0] CHAR_N = 8'h4E;

    // window length per phase, the first one is the reset value and is not written
    localparam logic [kgcp_pkg::NMER_W-1:0] LEN_PLAN [NUM_PHASES] =
        '{3'd2, 3'd4, 3'd1, 3'd0, 3'd7, 3'd3, 3'd5, 3'd6, 3'd2};

    // running n-mer profile and the read-out results it predicts
    class profile_board;
        logic [kgcp_pkg::CNT_W-1:0]  bin_mem  [NUM_SLOTS << BIN_BITS];
        logic [kgcp_pkg::CNT_W-1:0]  win_tot  [NUM_SLOTS];
        logic [kgcp_pkg::CNT_W-1:0]  gc_tot   [NUM_SLOTS];
        logic [kgcp_pkg::CNT_W-1:0]  base_tot [NUM_SLOTS];
        logic [BIN_BITS-1:0]         recent;
        int unsigned                 held;
        int unsigned                 clean;
        logic [kgcp_pkg::NMER_W-1:0] nmer_len;
        logic [BIN_BITS-1:0]         last_fwd;
        kgcp_pkg::result_t           readout_q [$];
        int                          errors;

        function new();
            foreach (bin_mem[i]) bin_mem[i] = '0;
            foreach (win_tot[i])
            begin
                win_tot[i]  = '0;
                gc_tot[i]   = '0;
                base_tot[i] = '0;
            end
            recent   = '0;
            held     = 0;
            clean    = 0;
            nmer_len = 3'd2;
            last_fwd = '0;
            errors   = 0;
        endfunction

        function logic [kgcp_pkg::CNT_W-1:0] bump(logic [kgcp_pkg::CNT_W-1:0] v,
                                                  logic [kgcp_pkg::CNT_W-1:0] d);
            return (v > kgcp_pkg::SAT_MAX - d) ? kgcp_pkg::SAT_MAX : v + d;
        endfunction

        // zero acts as one, anything past the built maximum acts as the maximum
        function int unsigned window_len();
            if (nmer_len == 0) return 1;
            if (nmer_len > MAX_LEN) return MAX_LEN;
            return nmer_len;
        endfunction

        // slot is six bits wide, so it is always inside the store
        function void count_base(logic [5:0] slot, logic [7:0] ch, logic lst);
            int unsigned         n;
            logic                ok;
            logic [1:0]          code;
            logic [BIN_BITS-1:0] mask;
            logic [BIN_BITS-1:0] fwd;
            logic [BIN_BITS-1:0] rc;
            logic [BIN_BITS-1:0] f;
            n  = window_len();
            ok = 1'b1;
            case (ch)
                kgcp_pkg::CHAR_A, kgcp_pkg::CHAR_A_LO: code = kgcp_pkg::CODE_A;
                kgcp_pkg::CHAR_C, kgcp_pkg::CHAR_C_LO: code = kgcp_pkg::CODE_C;
                kgcp_pkg::CHAR_G, kgcp_pkg::CHAR_G_LO: code = kgcp_pkg::CODE_G;
                kgcp_pkg::CHAR_T, kgcp_pkg::CHAR_T_LO: code = kgcp_pkg::CODE_T;
                default:
                begin
                    ok   = 1'b0;
                    code = kgcp_pkg::CODE_A;
                end
            endcase
            recent = {recent[BIN_BITS-3:0], code};
            if (held < MAX_LEN) held++;
            if (!ok) clean = 0;
            else if (clean < MAX_LEN) clean++;

            base_tot[slot] = bump(base_tot[slot], 1);
            if (ok && (code == kgcp_pkg::CODE_C || code == kgcp_pkg::CODE_G))
                gc_tot[slot] = bump(gc_tot[slot], 1);
            if (held >= n)
            begin
                win_tot[slot] = bump(win_tot[slot], 2);
                // clean window: forward bin and its reverse complement
                if (clean >= n)
                begin
                    mask = BIN_BITS'((1 << (2 * n)) - 1);
                    fwd  = recent & mask;
                    f    = fwd;
                    rc   = '0;
                    for (int i = 0; i < n; i++)
                    begin
                        rc = {rc[BIN_BITS-3:0], 2'(kgcp_pkg::CODE_T - f[1:0])};
                        f  = f >> 2;
                    end
                    bin_mem[{slot, fwd}] = bump(bin_mem[{slot, fwd}], 1);
                    bin_mem[{slot, rc}]  = bump(bin_mem[{slot, rc}], 1);
                    last_fwd = fwd;
                end
            end
            if (lst)
            begin
                recent = '0;
                held   = 0;
                clean  = 0;
            end
        endfunction

        // accepted input transaction
        function void note_item(logic md, logic [5:0] slot, logic [7:0] ch, logic lst,
                                logic [7:0] bin);
            kgcp_pkg::result_t r;
            if (md == kgcp_pkg::MODE_READ)
            begin
                r.bin_count         = bin_mem[{slot, bin}];
                r.totals.window_sum = win_tot[slot];
                r.totals.gc_sum     = gc_tot[slot];
                r.totals.base_sum   = base_tot[slot];
                readout_q = {readout_q, r};
            end
            else
            begin
                count_base(slot, ch, lst);
            end
        endfunction

        function int pending();
            return readout_q.size();
        endfunction

        task report(string msg);
            errors++;
            $display("mismatch: %s", msg);
        endtask

        task check_field(string name, logic [kgcp_pkg::CNT_W-1:0] got,
                         logic [kgcp_pkg::CNT_W-1:0] want);
            if (got !== want) report($sformatf("%s got %0d want %0d", name, got, want));
        endtask

        // accepted output transaction against the oldest read-out
        task check_readout(logic [kgcp_pkg::CNT_W-1:0] bc, logic [kgcp_pkg::CNT_W-1:0] ws,
                           logic [kgcp_pkg::CNT_W-1:0] gs, logic [kgcp_pkg::CNT_W-1:0] bs);
            kgcp_pkg::result_t w;
            if (readout_q.size() == 0)
            begin
                report($sformatf("read-out result with none outstanding, bin_count %0d", bc));
                return;
            end
            w = readout_q.pop_front();
            check_field("bin_count", bc, w.bin_count);
            check_field("window_sum", ws, w.totals.window_sum);
            check_field("gc_sum", gs, w.totals.gc_sum);
            check_field("base_sum", bs, w.totals.base_sum);
        endtask
    endclass

    logic                           clk;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_ready;
    logic                           mode;
    logic [kgcp_pkg::SLOT_IN_W-1:0] barcode_slot;
    logic [7:0]                     base_char;
    logic                           last_base;
    logic [7:0]                     bin_index;
    logic                           out_valid;
    logic                           out_ready;
    logic [kgcp_pkg::CNT_W-1:0]     bin_count;
    logic [kgcp_pkg::CNT_W-1:0]     window_sum;
    logic [kgcp_pkg::CNT_W-1:0]     gc_sum;
    logic [kgcp_pkg::CNT_W-1:0]     base_sum;
    logic                           cfg_wr_en;
    logic [kgcp_pkg::NMER_W-1:0]    cfg_wr_data;

    profile_board sb;
    int           burst_left;
    bit           hold_req;
    int           cycles;

    kmer_gc_profile_per_barcode_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .barcode_slot(barcode_slot),
        .base_char   (base_char),
        .last_base   (last_base),
        .bin_index   (bin_index),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .bin_count   (bin_count),
        .window_sum  (window_sum),
        .gc_sum      (gc_sum),
        .base_sum    (base_sum),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // run limit
    initial
    begin
        cycles = 0;
        while (cycles < LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // transaction monitor on both channels
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.check_readout(bin_count, window_sum, gc_sum, base_sum);
            if (in_valid && in_ready)
                sb.note_item(mode, barcode_slot, base_char, last_base, bin_index);
        end
    end

    // receiver: segments of random stall density, plus one long hold-off on request
    initial
    begin
        int seg_left;
        int stall_pct;
        out_ready = 1'b0;
        seg_left  = 0;
        stall_pct = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    seg_left = $urandom_range(10, 60);
                    case ($urandom_range(0, 3))
                        0:       stall_pct = 0;
                        1:       stall_pct = 30;
                        2:       stall_pct = 60;
                        default: stall_pct = 95;
                    endcase
                end
                seg_left--;
                out_ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
        begin
            case ($urandom_range(0, 7))
                0:       return kgcp_pkg::CHAR_A;
                1:       return kgcp_pkg::CHAR_C;
                2:       return kgcp_pkg::CHAR_G;
                3:       return kgcp_pkg::CHAR_T;
                4:       return kgcp_pkg::CHAR_A_LO;
                5:       return kgcp_pkg::CHAR_C_LO;
                6:       return kgcp_pkg::CHAR_G_LO;
                default: return kgcp_pkg::CHAR_T_LO;
            endcase
        end
        if (r < 88) return CHAR_N;
        return 8'($urandom_range(0, 255));
    endfunction

    // a few hot slots so counts build up, plus the full range
    function automatic logic [5:0] pick_slot();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 6'($urandom_range(0, 3));
        if (r < 70) return 6'd63;
        return 6'($urandom_range(0, 63));
    endfunction

    function automatic logic [7:0] pick_bin();
        case ($urandom_range(0, 2))
            0:       return sb.last_fwd;
            1:       return 8'($urandom_range(0, 15));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // one input transaction, valid held until accepted
    task automatic send_item(logic md, logic [5:0] slot, logic [7:0] ch, logic lst,
                             logic [7:0] bin);
        in_valid     <= 1'b1;
        mode         <= md;
        barcode_slot <= slot;
        base_char    <= ch;
        last_base    <= lst;
        bin_index    <= bin;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // sender bursts with random gaps between them
    task automatic send_paced(logic md, logic [5:0] slot, logic [7:0] ch, logic lst,
                              logic [7:0] bin);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        send_item(md, slot, ch, lst, bin);
    endtask

    task automatic send_base(logic [5:0] slot, logic [7:0] ch, logic lst);
        send_paced(kgcp_pkg::MODE_BASE, slot, ch, lst, 8'($urandom_range(0, 255)));
    endtask

    // base_char and last_base are don't-care on a read-out
    task automatic send_readout(logic [5:0] slot, logic [7:0] bin);
        send_paced(kgcp_pkg::MODE_READ, slot, 8'($urandom_range(0, 255)),
                   1'($urandom_range(0, 1)), bin);
    endtask

    task automatic write_len(logic [kgcp_pkg::NMER_W-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sb.nmer_len = v;
    endtask

    // let outstanding read-outs return and the last bases retire
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() > 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic directed();
        // untouched store after the clearing pass
        send_readout(6'd0, 8'd0);
        // mixed case read, CG window is its own reverse complement
        send_base(6'd0, kgcp_pkg::CHAR_A, 1'b0);
        send_base(6'd0, kgcp_pkg::CHAR_C_LO, 1'b0);
        send_base(6'd0, kgcp_pkg::CHAR_G, 1'b0);
        send_base(6'd0, kgcp_pkg::CHAR_T_LO, 1'b1);
        send_readout(6'd0, 8'h06);
        send_readout(6'd0, 8'hFF);
        // unknown characters only count toward the totals
        send_base(6'd63, CHAR_N, 1'b0);
        send_base(6'd63, kgcp_pkg::CHAR_A, 1'b0);
        send_base(6'd63, 8'hFF, 1'b0);
        send_base(6'd63, 8'h00, 1'b1);
        send_readout(6'd63, 8'h00);
        // slot switch inside a read, window lands in the second slot
        send_base(6'd1, kgcp_pkg::CHAR_G, 1'b0);
        send_base(6'd2, kgcp_pkg::CHAR_C, 1'b1);
        send_readout(6'd2, 8'h09);
        send_readout(6'd1, 8'h09);
        // single-base read
        send_base(6'd7, kgcp_pkg::CHAR_T, 1'b1);
        send_readout(6'd7, 8'h00);
        // read left open, it carries on into the random traffic
        send_base(6'd5, kgcp_pkg::CHAR_A_LO, 1'b0);
        send_base(6'd5, kgcp_pkg::CHAR_C, 1'b0);
        send_base(6'd5, kgcp_pkg::CHAR_G_LO, 1'b0);
    endtask

    // mostly well-formed reads with read-outs mixed in, some noise and unterminated reads
    task automatic random_phase(int n_items);
        int         sent;
        int         len;
        int         r;
        logic [5:0] slot;
        sent = 0;
        while (sent < n_items)
        begin
            r = $urandom_range(0, 99);
            if (r < 20)
            begin
                send_readout(pick_slot(), pick_bin());
                sent++;
            end
            else if (r < 27)
            begin
                send_base(6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)));
                sent++;
            end
            else
            begin
                len  = $urandom_range(1, 12);
                slot = pick_slot();
                for (int i = 0; i < len && sent < n_items; i++)
                begin
                    if ($urandom_range(0, 19) == 0) slot = pick_slot();
                    if ($urandom_range(0, 7) == 0)
                    begin
                        send_readout(pick_slot(), pick_bin());
                        sent++;
                    end
                    send_base(slot, pick_char(), i == len - 1 && $urandom_range(0, 9) != 0);
                    sent++;
                end
            end
        end
    endtask

    // receiver holds off while read-outs keep coming back to back
    task automatic pressure();
        hold_req = 1'b1;
        for (int i = 0; i < 40; i++)
            send_item(kgcp_pkg::MODE_READ, pick_slot(), pick_char(),
                      1'($urandom_range(0, 1)), pick_bin());
    endtask

    initial
    begin
        int guard;
        sb           = new();
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        mode         = kgcp_pkg::MODE_BASE;
        barcode_slot = '0;
        base_char    = '0;
        last_base    = 1'b0;
        bin_index    = '0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        hold_req     = 1'b0;
        burst_left   = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // wait out the clearing pass
        @(posedge clk);
        while (!in_ready) @(posedge clk);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if (p > 0)
            begin
                drain();
                write_len(LEN_PLAN[p]);
            end
            if (p == 0) directed();
            if (p == 3) pressure();
            random_phase(PHASE_ITEMS);
        end

        // final drain with its own bound
        in_valid <= 1'b0;
        guard = 0;
        while (sb.pending() > 0 && guard < 5000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE) @(posedge clk);
        if (sb.pending() > 0)
            sb.report($sformatf("%0d read-out results never arrived", sb.pending()));

        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/kgcp_pkg.sv
rtl/kmer_gc_profile_per_barcode_top.sv
test/kmer_gc_profile_per_barcode_top_tb.sv
